### rtl/bft_pkg.sv
package bft_pkg;

    localparam int unsigned DefBuckets = 256;
    localparam int unsigned DefWays    = 4;

    localparam logic [1:0] STATUS_NEW     = 2'd0;
    localparam logic [1:0] STATUS_UPDATED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam int unsigned SlotWidth  = 10;
    localparam int unsigned FlowsWidth = 11;

    typedef struct packed {
        logic       load;
        logic       lookup;
        logic       commit;
        logic       out_set;
    } bft_cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       clearing;
    } bft_status_t;

endpackage

### rtl/bft_ctrl.sv
module bft_ctrl
    import bft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output bft_cmd_t    cmd,
    input  bft_status_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !stat.clearing;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !stat.clearing)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.lookup = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_set    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/bft_datapath.sv
module bft_datapath
    import bft_pkg::*;
#(
    parameter int unsigned BUCKETS = DefBuckets,
    parameter int unsigned WAYS    = DefWays
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bft_cmd_t              cmd,
    output bft_status_t           stat,
    input  logic [31:0]           hash_seed,
    input  logic [31:0]           source_address,
    input  logic [31:0]           dest_address,
    input  logic [15:0]           source_port,
    input  logic [15:0]           dest_port,
    input  logic [7:0]            proto_number,
    input  logic [15:0]           length_bytes,
    output logic [1:0]            status,
    output logic [SlotWidth-1:0]  flow_slot,
    output logic                  from_high_side,
    output logic [31:0]           side_packets,
    output logic [31:0]           side_bytes,
    output logic [FlowsWidth-1:0] flows_total
);

    localparam int unsigned Entries = BUCKETS * WAYS;
    localparam int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned EW      = $clog2(Entries);
    localparam int unsigned KeyW    = 32 + 32 + 32 + 8;

    typedef logic [KeyW-1:0] key_t;

    // Key and counters in separate memories; a transfer reads one way per cycle.
    key_t        key_mem [Entries];
    logic [63:0] low_mem [Entries];
    logic [63:0] high_mem [Entries];
    logic        valid_mem [Entries];

    key_t        key_reg;
    logic        high_reg;
    logic [15:0] len_reg;
    logic [EW-1:0] base_reg;
    logic [WW:0] way_reg;
    logic        rd_pend_reg;
    logic [EW-1:0] rd_addr_reg;
    key_t        rd_key_reg;
    logic [63:0] rd_low_reg;
    logic [63:0] rd_high_reg;
    logic        rd_valid_reg;
    logic        found_reg;
    logic        free_reg;
    logic [EW-1:0] slot_reg;
    logic [63:0] cnt_reg;
    logic [FlowsWidth-1:0] flows_reg;
    logic [1:0]  st_reg;
    logic [31:0] pk_reg;
    logic [31:0] by_reg;
    logic        clr_busy_reg;
    logic [EW-1:0] clr_addr_reg;

    logic          hs;
    logic [31:0]   lo_a;
    logic [31:0]   hi_a;
    logic [15:0]   lo_p;
    logic [15:0]   hi_p;
    logic [31:0]   hash;
    logic [EW-1:0] rd_addr;
    logic          rd_valid;
    logic          match;
    logic [63:0]   sel_cnt;
    logic [63:0]   new_cnt;
    logic [1:0]    st_c;

    assign hs   = source_address > dest_address;
    assign lo_a = hs ? dest_address : source_address;
    assign hi_a = hs ? source_address : dest_address;
    assign lo_p = hs ? dest_port : source_port;
    assign hi_p = hs ? source_port : dest_port;
    assign hash = hash_seed ^ lo_a ^ hi_a ^ {16'd0, lo_p} ^ {16'd0, hi_p}
                  ^ {24'd0, proto_number};

    assign rd_addr        = base_reg + EW'(way_reg[WW-1:0]);
    assign stat.scan_done = rd_pend_reg && (way_reg == (WW+1)'(WAYS));
    assign stat.clearing  = clr_busy_reg;
    assign rd_valid       = rd_valid_reg;
    assign match          = rd_valid && (rd_key_reg == key_reg);

    assign st_c    = found_reg ? STATUS_UPDATED : (free_reg ? STATUS_NEW : STATUS_FULL);
    assign sel_cnt = found_reg ? cnt_reg : 64'd0;
    assign new_cnt = {sel_cnt[63:32] + 32'd1, sel_cnt[31:0] + {16'd0, len_reg}};

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && !stat.scan_done)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_low_reg   <= low_mem[rd_addr];
            rd_high_reg  <= high_mem[rd_addr];
            rd_valid_reg <= valid_mem[rd_addr];
        end
        if (clr_busy_reg)
        begin
            valid_mem[clr_addr_reg] <= 1'b0;
        end
        else if (cmd.commit && !found_reg && free_reg)
        begin
            valid_mem[slot_reg] <= 1'b1;
        end
        if (cmd.commit && st_c != STATUS_FULL)
        begin
            if (!found_reg)
            begin
                key_mem[slot_reg] <= key_reg;
            end
            if (high_reg)
            begin
                high_mem[slot_reg] <= new_cnt;
                if (!found_reg)
                begin
                    low_mem[slot_reg] <= 64'd0;
                end
            end
            else
            begin
                low_mem[slot_reg] <= new_cnt;
                if (!found_reg)
                begin
                    high_mem[slot_reg] <= 64'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= {lo_a, hi_a, lo_p, hi_p, proto_number};
            high_reg <= hs;
            len_reg  <= length_bytes;
            base_reg <= EW'(BW'(hash) * WAYS);
        end
        if (cmd.lookup)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (cmd.lookup && rd_pend_reg && !found_reg && match)
        begin
            cnt_reg <= high_reg ? rd_high_reg : rd_low_reg;
        end
        if (cmd.commit)
        begin
            st_reg <= st_c;
            pk_reg <= (st_c == STATUS_FULL) ? 32'd0 : new_cnt[63:32];
            by_reg <= (st_c == STATUS_FULL) ? 32'd0 : new_cnt[31:0];
        end
        if (cmd.out_set)
        begin
            status         <= st_reg;
            flow_slot      <= (st_reg == STATUS_FULL) ? '0 : SlotWidth'(slot_reg);
            from_high_side <= high_reg;
            side_packets   <= pk_reg;
            side_bytes     <= by_reg;
            flows_total    <= flows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flows_reg    <= '0;
            way_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            slot_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == EW'(Entries - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.load)
            begin
                way_reg     <= '0;
                rd_pend_reg <= 1'b0;
                found_reg   <= 1'b0;
                free_reg    <= 1'b0;
            end
            if (cmd.lookup && !stat.scan_done)
            begin
                way_reg     <= way_reg + 1'b1;
                rd_pend_reg <= 1'b1;
            end
            if (cmd.lookup && rd_pend_reg && !found_reg)
            begin
                if (match)
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= rd_addr_reg;
                end
                else if (!rd_valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                    slot_reg <= rd_addr_reg;
                end
            end
            if (cmd.commit && !found_reg && free_reg)
            begin
                flows_reg <= flows_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/bidirectional_flow_tracker.sv
// One packet is taken at a time. A lookup reads the bucket's ways one per cycle from the
// table memory, then a commit step writes back the entry, and the result is then
// registered on the outputs once the previous result has been taken; only then can the
// next packet be taken. After reset a clearing pass over all BUCKETS * WAYS entries
// (1024 by default) empties the table, and no transfer is taken until it has finished.
module bidirectional_flow_tracker
    import bft_pkg::*;
#(
    parameter int unsigned BUCKETS = DefBuckets,
    parameter int unsigned WAYS    = DefWays
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           source_address,
    input  logic [31:0]           dest_address,
    input  logic [15:0]           source_port,
    input  logic [15:0]           dest_port,
    input  logic [7:0]            proto_number,
    input  logic [15:0]           length_bytes,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [SlotWidth-1:0]  flow_slot,
    output logic                  from_high_side,
    output logic [31:0]           side_packets,
    output logic [31:0]           side_bytes,
    output logic [FlowsWidth-1:0] flows_total
);

    localparam logic [2:0] ADDR_HASH_SEED = 3'd0;

    logic [31:0] seed_reg;
    bft_cmd_t    cmd;
    bft_status_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HASH_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_HASH_SEED)
        begin
            seed_reg <= pwdata;
        end
    end

    bft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bft_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .hash_seed      (seed_reg),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .proto_number   (proto_number),
        .length_bytes   (length_bytes),
        .status         (status),
        .flow_slot      (flow_slot),
        .from_high_side (from_high_side),
        .side_packets   (side_packets),
        .side_bytes     (side_bytes),
        .flows_total    (flows_total)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Transfer accepted while busy.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_NEW || status == STATUS_UPDATED
                       || status == STATUS_FULL))
        else $error("Bad status code.");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_FULL) |-> (side_packets == 32'd0 && flow_slot == '0))
        else $error("Dropped packet reports counters.");

endmodule
